### rtl/hrp_pkg.sv
// Shared types, codes and character helpers for the HTTP request header parser.
package hrp_pkg;

  // Fixed widths of the result fields
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned START_W = 13;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned ERR_W   = 3;

  // Parse phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_METHOD     = 4'd1;
  localparam logic [3:0] PH_TARGET     = 4'd2;
  localparam logic [3:0] PH_VERSION    = 4'd3;
  localparam logic [3:0] PH_RL_CR      = 4'd4;
  localparam logic [3:0] PH_RL_LF      = 4'd5;
  localparam logic [3:0] PH_LINE_START = 4'd6;
  localparam logic [3:0] PH_NAME       = 4'd7;
  localparam logic [3:0] PH_VALUE      = 4'd8;
  localparam logic [3:0] PH_HDR_LF     = 4'd9;
  localparam logic [3:0] PH_END_LF     = 4'd10;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_METHOD  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_VERSION = 3'd2;
  localparam logic [ERR_W-1:0] ERR_MISSING_LF  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_NAME    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_EMPTY_VALUE = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TOO_LONG    = 3'd6;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // Number of fixed characters before the minor version digit ("HTTP/1.")
  localparam logic [2:0] VERSION_PREFIX_LEN = 3'd7;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] span_a_start;
    logic [LEN_W-1:0]   span_a_length;
    logic [START_W-1:0] span_b_start;
    logic [LEN_W-1:0]   span_b_length;
    logic               version_minor;
    logic [ERR_W-1:0]   error_code;
  } hrp_result_t;

  // RFC 7230 tchar
  function automatic logic is_token(input logic [7:0] c);
    logic r;
    r = ((c >= 8'h61) && (c <= 8'h7A)) ||
        ((c >= 8'h41) && (c <= 8'h5A)) ||
        ((c >= 8'h30) && (c <= 8'h39)) ||
        (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
        (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
        (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
        (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
    return r;
  endfunction

  // Expected character of "HTTP/1." at a given index
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h48;  // H
      3'd1:    r = 8'h54;  // T
      3'd2:    r = 8'h54;  // T
      3'd3:    r = 8'h50;  // P
      3'd4:    r = 8'h2F;  // /
      3'd5:    r = 8'h31;  // 1
      3'd6:    r = 8'h2E;  // .
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/hrp_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module hrp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hrp_pkg::hrp_result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output hrp_pkg::hrp_result_t out_data
);
  import hrp_pkg::*;

  logic        skid_valid;
  hrp_result_t skid_data;
  logic        take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // Control: refill the output register from skid first, then from a new item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload: hold while stalled, advance in order
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

### rtl/http_request_header_parser.sv
// A result item is registered in the result buffer before it appears on out_valid.
// Throughput: one byte per cycle when in_stall is low; state updates in the accept cycle.
// A two-entry result buffer keeps input flowing while one result waits downstream;
// in_stall rises only when both entries hold results.
// Reset: parse goes idle (bytes ignored until first_byte), offsets clear, buffer empties.
module http_request_header_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        first_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hrp_pkg::KIND_W-1:0]  kind,
  output logic [hrp_pkg::START_W-1:0] span_a_start,
  output logic [hrp_pkg::LEN_W-1:0]   span_a_length,
  output logic [hrp_pkg::START_W-1:0] span_b_start,
  output logic [hrp_pkg::LEN_W-1:0]   span_b_length,
  output logic                        version_minor,
  output logic [hrp_pkg::ERR_W-1:0]   error_code
);
  import hrp_pkg::*;

  localparam int unsigned OW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [OW-1:0] MAX_OFS = OW'(MAX_MESSAGE_BYTES);

  // Parse state
  logic [3:0]    phase;
  logic [OW-1:0] byte_offset;
  logic [2:0]    literal_index;
  logic          minor_seen;
  logic [OW-1:0] first_span_start;
  logic [OW-1:0] first_span_length;
  logic [OW-1:0] second_span_start;
  logic [OW-1:0] last_nonspace_offset;
  logic          value_nonempty;

  logic [3:0]    phase_next;
  logic [OW-1:0] byte_offset_next;
  logic [2:0]    literal_index_next;
  logic          minor_seen_next;
  logic [OW-1:0] first_span_start_next;
  logic [OW-1:0] first_span_length_next;
  logic [OW-1:0] second_span_start_next;
  logic [OW-1:0] last_nonspace_offset_next;
  logic          value_nonempty_next;

  // State as seen by this byte (cleared on first_byte)
  logic [3:0]    ph;
  logic [OW-1:0] pos;
  logic [2:0]    lit;
  logic          mnr;
  logic [OW-1:0] fss;
  logic [OW-1:0] fsl;
  logic [OW-1:0] sss;
  logic [OW-1:0] lno;
  logic          vne;

  logic          accept;
  logic          res_valid;
  hrp_result_t   res;
  hrp_result_t   out_data;
  logic          buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // Per-byte parse step
  always_comb begin
    ph  = phase;
    pos = byte_offset;
    lit = literal_index;
    mnr = minor_seen;
    fss = first_span_start;
    fsl = first_span_length;
    sss = second_span_start;
    lno = last_nonspace_offset;
    vne = value_nonempty;
    if (first_byte) begin
      ph  = PH_METHOD;
      pos = '0;
      lit = '0;
      mnr = 1'b0;
      fss = '0;
      fsl = '0;
      sss = '0;
      lno = '0;
      vne = 1'b0;
    end

    phase_next                = ph;
    byte_offset_next          = pos;
    literal_index_next        = lit;
    minor_seen_next           = mnr;
    first_span_start_next     = fss;
    first_span_length_next    = fsl;
    second_span_start_next    = sss;
    last_nonspace_offset_next = lno;
    value_nonempty_next       = vne;
    res_valid                 = 1'b0;
    res                       = '0;

    if (ph != PH_IDLE) begin
      if (pos >= MAX_OFS) begin
        // Too long: report and drop the rest
        phase_next     = PH_IDLE;
        res_valid      = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_TOO_LONG;
      end else begin
        byte_offset_next = pos + 1'b1;
        unique case (ph)
          PH_METHOD: begin
            if (data_byte == CH_SPACE) begin
              if (pos == '0) begin
                phase_next     = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_BAD_METHOD;
              end else begin
                first_span_start_next  = '0;
                first_span_length_next = pos;
                second_span_start_next = pos + 1'b1;
                phase_next             = PH_TARGET;
              end
            end else if (!is_token(data_byte)) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_METHOD;
            end
          end
          PH_TARGET: begin
            if (data_byte == CH_SPACE) begin
              last_nonspace_offset_next = pos;
              literal_index_next        = '0;
              phase_next                = PH_VERSION;
            end
          end
          PH_VERSION: begin
            if (lit < VERSION_PREFIX_LEN) begin
              if (data_byte != version_char(lit)) begin
                phase_next     = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_BAD_VERSION;
              end else begin
                literal_index_next = lit + 1'b1;
              end
            end else if (data_byte != CH_ZERO && data_byte != CH_ONE) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_VERSION;
            end else begin
              minor_seen_next = data_byte[0];
              phase_next      = PH_RL_CR;
            end
          end
          PH_RL_CR: begin
            if (data_byte != CH_CR) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MISSING_LF;
            end else begin
              phase_next = PH_RL_LF;
            end
          end
          PH_RL_LF: begin
            res_valid = 1'b1;
            if (data_byte != CH_LF) begin
              phase_next     = PH_IDLE;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MISSING_LF;
            end else begin
              res.kind          = KIND_REQUEST;
              res.span_a_start  = START_W'(fss);
              res.span_a_length = LEN_W'(fsl);
              res.span_b_start  = START_W'(sss);
              res.span_b_length = LEN_W'(lno - sss);
              res.version_minor = mnr;
              phase_next        = PH_LINE_START;
            end
          end
          PH_LINE_START: begin
            if (data_byte == CH_CR) begin
              phase_next = PH_END_LF;
            end else if (is_token(data_byte)) begin
              first_span_start_next = pos;
              phase_next            = PH_NAME;
            end else begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_NAME;
            end
          end
          PH_NAME: begin
            if (data_byte == CH_COLON) begin
              first_span_length_next = pos - fss;
              value_nonempty_next    = 1'b0;
              phase_next             = PH_VALUE;
            end else if (!is_token(data_byte)) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_NAME;
            end
          end
          PH_VALUE: begin
            // Skip leading spaces, track last non-space for the right trim
            if (data_byte == CH_CR) begin
              phase_next = PH_HDR_LF;
            end else if (data_byte != CH_SPACE) begin
              if (!vne) begin
                second_span_start_next = pos;
              end
              value_nonempty_next       = 1'b1;
              last_nonspace_offset_next = pos;
            end
          end
          PH_HDR_LF: begin
            res_valid = 1'b1;
            if (data_byte != CH_LF) begin
              phase_next     = PH_IDLE;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MISSING_LF;
            end else if (!vne) begin
              phase_next     = PH_IDLE;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_EMPTY_VALUE;
            end else begin
              res.kind          = KIND_HEADER;
              res.span_a_start  = START_W'(fss);
              res.span_a_length = LEN_W'(fsl);
              res.span_b_start  = START_W'(sss);
              res.span_b_length = LEN_W'(lno - sss + 1'b1);
              phase_next        = PH_LINE_START;
            end
          end
          PH_END_LF: begin
            res_valid  = 1'b1;
            phase_next = PH_IDLE;
            if (data_byte != CH_LF) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MISSING_LF;
            end else begin
              res.kind          = KIND_DONE;
              res.span_a_length = LEN_W'(pos + 1'b1);
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Advance the parse state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      byte_offset          <= '0;
      literal_index        <= '0;
      minor_seen           <= 1'b0;
      first_span_start     <= '0;
      first_span_length    <= '0;
      second_span_start    <= '0;
      last_nonspace_offset <= '0;
      value_nonempty       <= 1'b0;
    end else if (accept) begin
      phase                <= phase_next;
      byte_offset          <= byte_offset_next;
      literal_index        <= literal_index_next;
      minor_seen           <= minor_seen_next;
      first_span_start     <= first_span_start_next;
      first_span_length    <= first_span_length_next;
      second_span_start    <= second_span_start_next;
      last_nonspace_offset <= last_nonspace_offset_next;
      value_nonempty       <= value_nonempty_next;
    end
  end

  // Result buffer
  hrp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind          = out_data.kind;
  assign span_a_start  = out_data.span_a_start;
  assign span_a_length = out_data.span_a_length;
  assign span_b_start  = out_data.span_b_start;
  assign span_b_length = out_data.span_b_length;
  assign version_minor = out_data.version_minor;
  assign error_code    = out_data.error_code;

endmodule
